FILE: src/rwcs_pkg.sv
// Package for the radial wind cell source: shared widths, pipeline depths,
// register indexes and build-time options. No dependencies.
`default_nettype none
package rwcs_pkg;

    // Number of active axes and whether kinetic energy is added to the thermal term.
    localparam int RANK        = 3;
    localparam int ADD_KINETIC = 1;
    localparam int NUM_AXES    = 3;

    // Iterative units: one register level for the operands, then one level per bit.
    localparam int ROOT_W    = 32;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int QUO_W     = 32;
    localparam int DVD_W     = 2 * QUO_W;
    localparam int ITER_LAT  = QUO_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIND_RADIUS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIND_DENSITY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIND_SPEED     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THERMAL_ENERGY = 3'd7;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

FILE: src/rwcs_sqrt.sv
// Pipelined integer square root, one result bit per register level.
// Depends on rwcs_pkg.
`default_nettype none
module rwcs_sqrt (
    input  wire logic                       i_clk,
    input  wire logic [rwcs_pkg::RAD_W-1:0] i_rad,
    output logic      [rwcs_pkg::ROOT_W-1:0] o_root
);
    import rwcs_pkg::*;

    // The partial remainder never exceeds twice the partial root.
    logic [ROOT_W+1:0] r_rem  [0:ROOT_W];
    logic [RAD_W-1:0]  r_rad  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_rad[0]  <= i_rad;
        r_root[0] <= '0;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [ROOT_W+3:0] w_trial;
        logic [ROOT_W+3:0] w_test;
        logic              w_ge;

        assign w_trial = {r_rem[k], r_rad[k][RAD_W-1 -: 2]};
        assign w_test  = {2'b00, r_root[k], 2'b01};
        assign w_ge    = (w_trial >= w_test);

        always_ff @(posedge i_clk) begin
            if (w_ge) begin
                r_rem[k+1] <= (ROOT_W+2)'(w_trial - w_test);
            end else begin
                r_rem[k+1] <= w_trial[ROOT_W+1:0];
            end
            r_root[k+1] <= {r_root[k][ROOT_W-2:0], w_ge};
            r_rad[k+1]  <= {r_rad[k][RAD_W-3:0], 2'b00};
        end
    end

    assign o_root = r_root[ROOT_W];

endmodule
`default_nettype wire

FILE: src/rwcs_div.sv
// Pipelined restoring divider, one quotient bit per register level, with a
// flag for quotients that do not fit. Depends on rwcs_pkg.
`default_nettype none
module rwcs_div (
    input  wire logic                      i_clk,
    input  wire logic [rwcs_pkg::DVD_W-1:0] i_dvd,
    input  wire logic [rwcs_pkg::QUO_W-1:0] i_dvs,
    output logic      [rwcs_pkg::QUO_W-1:0] o_quo,
    output logic                            o_ovf
);
    import rwcs_pkg::*;

    logic [QUO_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic [QUO_W-1:0] r_dvs [0:QUO_W];
    logic             r_ovf [0:QUO_W];

    // The quotient fits in QUO_W bits exactly when the upper half is below the divisor.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_dvd[DVD_W-1:QUO_W];
        r_low[0] <= i_dvd[QUO_W-1:0];
        r_quo[0] <= '0;
        r_dvs[0] <= i_dvs;
        r_ovf[0] <= (i_dvd[DVD_W-1:QUO_W] >= i_dvs);
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [QUO_W:0] w_trial;
        logic           w_ge;

        assign w_trial = {r_rem[k], r_low[k][QUO_W-1]};
        assign w_ge    = (w_trial >= {1'b0, r_dvs[k]});

        always_ff @(posedge i_clk) begin
            if (w_ge) begin
                r_rem[k+1] <= QUO_W'(w_trial - {1'b0, r_dvs[k]});
            end else begin
                r_rem[k+1] <= w_trial[QUO_W-1:0];
            end
            r_quo[k+1] <= {r_quo[k][QUO_W-2:0], w_ge};
            r_low[k+1] <= {r_low[k][QUO_W-2:0], 1'b0};
            r_dvs[k+1] <= r_dvs[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule
`default_nettype wire

FILE: src/radial_wind_cell_source.sv
// Top level of the radial wind cell source: offsets, squared distance, root,
// divisions and output stage. Depends on rwcs_pkg, rwcs_sqrt and rwcs_div.
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  cell in   | start, busy         | i_left_x/y/z, i_width_x/y/z
//  result    | o_valid (strobe)    | o_inside_res, o_density, o_vel_x/y/z, o_energy
//  config    | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One cell is taken every cycle; busy stays low. Each result passes through the root
// pipeline and two chained divider pipelines (33 levels each) plus five single
// stages (offsets, squares, floored radius, density numerator, output), the first
// loaded at the transfer edge. Reset is synchronous and clears the valid bits and
// the configuration, but sets the minimum radius to one. Results cannot be stalled.
`default_nettype none
module radial_wind_cell_source (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_left_x,
    input  wire logic [31:0] i_left_y,
    input  wire logic [31:0] i_left_z,
    input  wire logic [30:0] i_width_x,
    input  wire logic [30:0] i_width_y,
    input  wire logic [30:0] i_width_z,
    input  wire logic                              i_cfg_we,
    input  wire logic [rwcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [rwcs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic             o_valid,
    output logic             o_inside_res,
    output logic [31:0]      o_density,
    output logic [31:0]      o_vel_x,
    output logic [31:0]      o_vel_y,
    output logic [31:0]      o_vel_z,
    output logic [31:0]      o_energy
);
    import rwcs_pkg::*;

    typedef struct packed {
        logic [NUM_AXES-1:0]       sgn;
        logic [NUM_AXES-1:0][30:0] mag;
    } t_side_a;

    typedef struct packed {
        logic [NUM_AXES-1:0] sgn;
        logic                in_wind;
        logic [QUO_W-1:0]    rad;
    } t_side_b;

    typedef struct packed {
        logic [NUM_AXES-1:0]       sgn;
        logic                      in_wind;
        logic                      ovf;
        logic [NUM_AXES-1:0][30:0] mag;
        logic [NUM_AXES-1:0][44:0] kin;
    } t_side_c;

    // Configuration registers.
    logic [31:0] r_center [NUM_AXES];
    logic [30:0] r_wind_radius;
    logic [30:0] r_min_radius;
    logic [30:0] r_wind_density;
    logic [30:0] r_wind_speed;
    logic [30:0] r_thermal;
    logic [61:0] r_wdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_center[a] <= '0;
            end
            r_wind_radius  <= '0;
            r_min_radius   <= 31'd1;
            r_wind_density <= '0;
            r_wind_speed   <= '0;
            r_thermal      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X:       r_center[0]    <= i_cfg_data;
                REG_CENTER_Y:       r_center[1]    <= i_cfg_data;
                REG_CENTER_Z:       r_center[2]    <= i_cfg_data;
                REG_WIND_RADIUS:    r_wind_radius  <= i_cfg_data[30:0];
                REG_MIN_RADIUS:     r_min_radius   <= i_cfg_data[30:0];
                REG_WIND_DENSITY:   r_wind_density <= i_cfg_data[30:0];
                REG_WIND_SPEED:     r_wind_speed   <= i_cfg_data[30:0];
                REG_THERMAL_ENERGY: r_thermal      <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Density numerator depends only on configuration.
    always_ff @(posedge i_clk) begin
        r_wdr <= {31'b0, r_wind_density} * {31'b0, r_wind_radius};
    end

    assign busy = 1'b0;

    // Stage 1: clamped offsets from the star center.
    logic [31:0] w_left  [NUM_AXES];
    logic [30:0] w_width [NUM_AXES];
    logic [NUM_AXES-1:0]       n_sgn1;
    logic [NUM_AXES-1:0][30:0] n_mag1;
    logic [NUM_AXES-1:0]       r_sgn1;
    logic [NUM_AXES-1:0][30:0] r_mag1;
    logic                      r_vld1;

    assign w_left[0]  = i_left_x;
    assign w_left[1]  = i_left_y;
    assign w_left[2]  = i_left_z;
    assign w_width[0] = i_width_x;
    assign w_width[1] = i_width_y;
    assign w_width[2] = i_width_z;

    always_comb begin
        logic signed [33:0] d;
        for (int a = 0; a < NUM_AXES; a++) begin
            d = $signed({{2{w_left[a][31]}}, w_left[a]})
              + $signed({4'b0, w_width[a][30:1]})
              - $signed({{2{r_center[a][31]}}, r_center[a]});
            if (d > 34'sh0_7FFF_FFFF) begin
                d = 34'sh0_7FFF_FFFF;
            end else if (d < -34'sh0_7FFF_FFFF) begin
                d = -34'sh0_7FFF_FFFF;
            end
            if (a < RANK) begin
                n_sgn1[a] = d[33];
                n_mag1[a] = d[33] ? 31'(-d) : d[30:0];
            end else begin
                n_sgn1[a] = 1'b0;
                n_mag1[a] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sgn1 <= n_sgn1;
        r_mag1 <= n_mag1;
    end

    // Stage 2: squares.
    logic [NUM_AXES-1:0][61:0] r_sq2;
    t_side_a                   r_sa2;
    logic                      r_vld2;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            r_sq2[a] <= {31'b0, r_mag1[a]} * {31'b0, r_mag1[a]};
        end
        r_sa2.sgn <= r_sgn1;
        r_sa2.mag <= r_mag1;
    end

    // Root of the summed squares; the side data waits alongside.
    logic [RAD_W-1:0]  w_sum;
    logic [ROOT_W-1:0] w_root;
    t_side_a           r_sa [ITER_LAT];
    logic [ITER_LAT-1:0] r_vld_a;

    assign w_sum = {2'b0, r_sq2[0]} + {2'b0, r_sq2[1]} + {2'b0, r_sq2[2]};

    rwcs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (w_sum),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        r_sa[0] <= r_sa2;
        for (int i = 1; i < ITER_LAT; i++) begin
            r_sa[i] <= r_sa[i-1];
        end
    end

    // Stage 4: floored radius, inside test and velocity numerators.
    logic [QUO_W-1:0] n_rad4;
    logic [QUO_W-1:0] r_rad4;
    logic             r_inside4;
    logic [NUM_AXES-1:0]       r_sgn4;
    logic [NUM_AXES-1:0][61:0] r_pv4;
    logic                      r_vld4;

    always_comb begin
        n_rad4 = (w_root < {1'b0, r_min_radius}) ? {1'b0, r_min_radius} : w_root;
        if (n_rad4 == '0) begin
            n_rad4 = 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad4    <= n_rad4;
        r_inside4 <= (n_rad4 < {1'b0, r_wind_radius});
        r_sgn4    <= r_sa[ITER_LAT-1].sgn;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_pv4[a] <= {31'b0, r_wind_speed} * {31'b0, r_sa[ITER_LAT-1].mag[a]};
        end
    end

    // First divisions: density intermediate and velocity magnitudes.
    logic [QUO_W-1:0] w_q1;
    logic             w_ovf1;
    logic [QUO_W-1:0] w_qv [NUM_AXES];
    logic             w_ovfv [NUM_AXES];
    t_side_b             r_sb [ITER_LAT];
    logic [ITER_LAT-1:0] r_vld_b;

    rwcs_div u_div_t (
        .i_clk (i_clk),
        .i_dvd ({2'b0, r_wdr}),
        .i_dvs (r_rad4),
        .o_quo (w_q1),
        .o_ovf (w_ovf1)
    );

    // The velocity quotient never exceeds the wind speed, so it always fits.
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_vel_div
        rwcs_div u_div_v (
            .i_clk (i_clk),
            .i_dvd ({2'b0, r_pv4[a]}),
            .i_dvs (r_rad4),
            .o_quo (w_qv[a]),
            .o_ovf (w_ovfv[a])
        );
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= '{sgn: r_sgn4, in_wind: r_inside4, rad: r_rad4};
        for (int i = 1; i < ITER_LAT; i++) begin
            r_sb[i] <= r_sb[i-1];
        end
    end

    // Stage 5: second density numerator and squared velocities.
    logic [62:0]               r_tr5;
    logic                      r_ovf5;
    logic [NUM_AXES-1:0][30:0] r_mag5;
    logic [NUM_AXES-1:0][61:0] r_msq5;
    logic [NUM_AXES-1:0]       r_sgn5;
    logic                      r_inside5;
    logic [QUO_W-1:0]          r_rad5;
    logic                      r_vld5;

    always_ff @(posedge i_clk) begin
        r_tr5     <= {31'b0, w_q1} * {32'b0, r_wind_radius};
        r_ovf5    <= w_ovf1;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_mag5[a] <= w_qv[a][30:0] & {31{~w_ovfv[a]}};
            r_msq5[a] <= {31'b0, w_qv[a][30:0]} * {31'b0, w_qv[a][30:0]};
        end
        r_sgn5    <= r_sb[ITER_LAT-1].sgn;
        r_inside5 <= r_sb[ITER_LAT-1].in_wind;
        r_rad5    <= r_sb[ITER_LAT-1].rad;
    end

    // Second division: final density.
    logic [QUO_W-1:0]    w_q2;
    logic                w_ovf2;
    t_side_c             r_sc [ITER_LAT];
    logic [ITER_LAT-1:0] r_vld_c;
    t_side_c             n_sc;

    rwcs_div u_div_d (
        .i_clk (i_clk),
        .i_dvd ({1'b0, r_tr5}),
        .i_dvs (r_rad5),
        .o_quo (w_q2),
        .o_ovf (w_ovf2)
    );

    always_comb begin
        n_sc.sgn     = r_sgn5;
        n_sc.in_wind = r_inside5;
        n_sc.ovf     = r_ovf5;
        n_sc.mag     = r_mag5;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (ADD_KINETIC != 0 && a < RANK) begin
                n_sc.kin[a] = r_msq5[a][61:17];
            end else begin
                n_sc.kin[a] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sc[0] <= n_sc;
        for (int i = 1; i < ITER_LAT; i++) begin
            r_sc[i] <= r_sc[i-1];
        end
    end

    // Output stage: saturation, signs and the outside case.
    t_side_c     w_fin;
    logic [46:0] w_en;
    logic [31:0] n_vel [NUM_AXES];

    assign w_fin = r_sc[ITER_LAT-1];
    assign w_en  = {16'b0, r_thermal} + {2'b0, w_fin.kin[0]}
                 + {2'b0, w_fin.kin[1]} + {2'b0, w_fin.kin[2]};

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_vel[a] = w_fin.sgn[a] ? 32'(-{1'b0, w_fin.mag[a]}) : {1'b0, w_fin.mag[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        o_inside_res <= w_fin.in_wind;
        if (w_fin.in_wind) begin
            o_density <= (w_fin.ovf || w_ovf2) ? SAT32 : w_q2;
            o_vel_x   <= n_vel[0];
            o_vel_y   <= n_vel[1];
            o_vel_z   <= n_vel[2];
            o_energy  <= (w_en[46:32] != '0) ? SAT32 : w_en[31:0];
        end else begin
            o_density <= '0;
            o_vel_x   <= '0;
            o_vel_y   <= '0;
            o_vel_z   <= '0;
            o_energy  <= '0;
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1  <= 1'b0;
            r_vld2  <= 1'b0;
            r_vld_a <= '0;
            r_vld4  <= 1'b0;
            r_vld_b <= '0;
            r_vld5  <= 1'b0;
            r_vld_c <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld1  <= start && !busy;
            r_vld2  <= r_vld1;
            r_vld_a <= {r_vld_a[ITER_LAT-2:0], r_vld2};
            r_vld4  <= r_vld_a[ITER_LAT-1];
            r_vld_b <= {r_vld_b[ITER_LAT-2:0], r_vld4};
            r_vld5  <= r_vld_b[ITER_LAT-1];
            r_vld_c <= {r_vld_c[ITER_LAT-2:0], r_vld5};
            o_valid <= r_vld_c[ITER_LAT-1];
        end
    end

    // The floored radius used as a divisor is never zero.
    a_rad_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> (r_rad4 != '0))
        else $error("radius divisor is zero");

    // A cell outside the wind radius gives all-zero values.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_res) |-> (o_density == '0 && o_energy == '0
            && o_vel_x == '0 && o_vel_y == '0 && o_vel_z == '0))
        else $error("outside cell has nonzero values");

    // A valid bit at stage 5 enters the density divider pipeline in the next cycle.
    a_valid_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld5 |=> r_vld_c[0])
        else $error("valid bit lost in density pipeline");

endmodule
`default_nettype wire
